// ----- sv/ysag_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ysag_pkg
// Shared types, widths and codes of the YUV sample address generator.
// ----------------------------------------------------------------------------
package ysag_pkg;

  // Field widths
  localparam int X_W        = 12;
  localparam int Y_W        = 12;
  localparam int PLANE_W    = 2;
  localparam int FMT_W      = 2;
  localparam int STRIDE_W   = 13;
  localparam int HEIGHT_W   = 13;
  localparam int ADDR_W     = 25;
  localparam int BIT_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // 4x4 tiles: log2 of the tile edge
  localparam int TILE_SHIFT = 2;

  // Pixel format codes
  localparam logic [FMT_W-1:0] FMT_I420    = 2'd0;
  localparam logic [FMT_W-1:0] FMT_NV12    = 2'd1;
  localparam logic [FMT_W-1:0] FMT_TILED8  = 2'd2;
  localparam logic [FMT_W-1:0] FMT_TILED10 = 2'd3;

  // Plane codes (U and V differ in bit 1 only; code three acts as V)
  localparam logic [PLANE_W-1:0] PLANE_Y = 2'd0;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_STRIDE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

  // Register reset values
  localparam logic [FMT_W-1:0]    RST_PIXEL_FORMAT = FMT_I420;
  localparam logic [STRIDE_W-1:0] RST_LINE_STRIDE  = 13'd1920;
  localparam logic [HEIGHT_W-1:0] RST_FRAME_HEIGHT = 13'd1080;

  typedef struct packed {
    logic [X_W-1:0]     x_pos;
    logic [Y_W-1:0]     y_pos;
    logic [PLANE_W-1:0] plane;
  } pixel_t;

  typedef struct packed {
    logic [ADDR_W-1:0] byte_address;
    logic [BIT_W-1:0]  bit_pos;
  } result_t;

  // Frame layout registers as seen by the datapath
  typedef struct packed {
    logic [FMT_W-1:0]    pixel_format;
    logic [STRIDE_W-1:0] line_stride;
    logic [HEIGHT_W-1:0] frame_height;
  } layout_t;

endpackage

// ----- sv/ysag_addr_pipe.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ysag_addr_pipe
// Five-stage address datapath: operand select, multiply, index add,
// 10-bit packing, final base add.
// ----------------------------------------------------------------------------
module ysag_addr_pipe (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  ysag_pkg::pixel_t  pixel,
  input  ysag_pkg::layout_t layout,
  output logic             out_valid,
  output ysag_pkg::result_t result
);
  import ysag_pkg::*;

  localparam int OPND_W = STRIDE_W;                  // multiplier operand width
  localparam int PROD_W = 2 * OPND_W;                // product width
  localparam int LIN_W  = X_W + TILE_SHIFT;          // in-tile / in-line term
  localparam int ELEM_W = PROD_W + TILE_SHIFT + 1;   // element index
  localparam int BITS_W = ELEM_W + 4;                // element index times ten
  localparam int LS10_W = PROD_W + 4;                // luma size times ten

  localparam logic [1:0] BASE_NONE   = 2'd0;
  localparam logic [1:0] BASE_LUMA   = 2'd1;
  localparam logic [1:0] BASE_PACKED = 2'd2;

  // Stage 1 operand select
  logic              chroma;
  logic              is_v;
  logic [LIN_W-1:0]  tile_idx;
  logic [OPND_W-1:0] mul_a;
  logic [OPND_W-1:0] mul_b;
  logic [LIN_W-1:0]  lin;
  logic              tiled;
  logic              packed_fmt;
  logic [1:0]        base_sel;

  always_comb begin
    chroma     = (pixel.plane != PLANE_Y);
    is_v       = pixel.plane[1];
    tile_idx   = {pixel.x_pos[X_W-1:TILE_SHIFT], pixel.y_pos[TILE_SHIFT-1:0],
                  pixel.x_pos[TILE_SHIFT-1:0]};
    mul_a      = layout.line_stride;
    mul_b      = OPND_W'(pixel.y_pos);
    lin        = LIN_W'(pixel.x_pos);
    tiled      = 1'b0;
    packed_fmt = 1'b0;
    base_sel   = chroma ? BASE_LUMA : BASE_NONE;
    unique case (layout.pixel_format)
      FMT_I420: begin
        // V folds its plane offset into the row term: (S/2)*(y/2 + H/2)
        if (chroma) begin
          mul_a = {1'b0, layout.line_stride[STRIDE_W-1:1]};
          mul_b = OPND_W'(pixel.y_pos[Y_W-1:1]) +
                  (is_v ? OPND_W'(layout.frame_height[HEIGHT_W-1:1]) : OPND_W'(0));
          lin   = LIN_W'(pixel.x_pos[X_W-1:1]);
        end
      end
      FMT_NV12: begin
        if (chroma) begin
          mul_b = OPND_W'(pixel.y_pos[Y_W-1:1]);
          lin   = LIN_W'({pixel.x_pos[X_W-1:1], is_v});
        end
      end
      FMT_TILED8, FMT_TILED10: begin
        tiled      = 1'b1;
        packed_fmt = (layout.pixel_format == FMT_TILED10);
        if (chroma) begin
          mul_b = OPND_W'(pixel.y_pos[Y_W-1:TILE_SHIFT+1]);
          lin   = {tile_idx[LIN_W-1:1], is_v};
        end else begin
          mul_b = OPND_W'(pixel.y_pos[Y_W-1:TILE_SHIFT]);
          lin   = tile_idx;
        end
        if (packed_fmt && chroma) begin
          base_sel = BASE_PACKED;
        end
      end
      default: begin
      end
    endcase
  end

  // Pipeline valid bits
  logic v1, v2, v3, v4, v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // Stage registers
  logic [OPND_W-1:0] s1_a, s1_b;
  logic [LIN_W-1:0]  s1_lin;
  logic              s1_tiled, s1_packed;
  logic [1:0]        s1_base_sel;

  logic [PROD_W-1:0] s2_prod, s2_luma;
  logic [LIN_W-1:0]  s2_lin;
  logic              s2_tiled, s2_packed;
  logic [1:0]        s2_base_sel;

  logic [ELEM_W-1:0] s3_elem;
  logic [ADDR_W-1:0] s3_base;
  logic              s3_packed;

  logic [ADDR_W-1:0] s4_part, s4_base;
  logic [BIT_W-1:0]  s4_bit;

  result_t           s5_result;

  logic [LS10_W-1:0] luma10;
  logic [ELEM_W-1:0] prod_scaled;
  logic [BITS_W-1:0] elem_bits;

  // Stage 3 and 4 arithmetic
  always_comb begin
    luma10      = LS10_W'({s2_luma, 3'b000}) + LS10_W'({s2_luma, 1'b0});
    prod_scaled = s2_tiled ? ELEM_W'({s2_prod, TILE_SHIFT'(0)}) : ELEM_W'(s2_prod);
    elem_bits   = BITS_W'({s3_elem, 3'b000}) + BITS_W'({s3_elem, 1'b0});
  end

  always_ff @(posedge clk) begin
    // Stage 1: operands
    s1_a        <= mul_a;
    s1_b        <= mul_b;
    s1_lin      <= lin;
    s1_tiled    <= tiled;
    s1_packed   <= packed_fmt;
    s1_base_sel <= base_sel;

    // Stage 2: row product and luma plane size
    s2_prod     <= PROD_W'(s1_a) * PROD_W'(s1_b);
    s2_luma     <= PROD_W'(layout.line_stride) * PROD_W'(layout.frame_height);
    s2_lin      <= s1_lin;
    s2_tiled    <= s1_tiled;
    s2_packed   <= s1_packed;
    s2_base_sel <= s1_base_sel;

    // Stage 3: element index and chroma base
    s3_elem   <= prod_scaled + ELEM_W'(s2_lin);
    s3_packed <= s2_packed;
    case (s2_base_sel)
      BASE_LUMA:   s3_base <= s2_luma[ADDR_W-1:0];
      BASE_PACKED: s3_base <= luma10[ADDR_W+2:3];
      default:     s3_base <= '0;
    endcase

    // Stage 4: 10-bit packing splits index*10 into byte and bit
    if (s3_packed) begin
      s4_part <= elem_bits[ADDR_W+2:3];
      s4_bit  <= elem_bits[2:0];
    end else begin
      s4_part <= s3_elem[ADDR_W-1:0];
      s4_bit  <= '0;
    end
    s4_base <= s3_base;

    // Stage 5: output word, wraps at 25 bits
    s5_result.byte_address <= s4_part + s4_base;
    s5_result.bit_pos      <= s4_bit;
  end

  assign out_valid = v5;
  assign result    = s5_result;

endmodule

// ----- sv/yuv_sample_address_generator_unit.sv -----
`timescale 1ns / 1ps
// Throughput: one word per clock; the five-stage datapath (13x13 multiply in
// stage 2) accepts a new pixel every cycle and busy is low outside reset.
// The result strobe lasts one cycle; the receiver cannot stall.
// Reset clears all pipeline valid bits and loads I420, stride 1920, height 1080.
// ----------------------------------------------------------------------------
// yuv_sample_address_generator_unit
// Byte address and bit offset of a Y, U or V sample in an I420, NV12,
// 4x4-tiled 8-bit or 4x4-tiled packed 10-bit frame buffer.
// ----------------------------------------------------------------------------
module yuv_sample_address_generator_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  ysag_pkg::pixel_t                pixel,
  output logic                            result_valid,
  output ysag_pkg::result_t               result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ysag_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ysag_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ysag_pkg::*;

  layout_t layout;
  logic    accept;
  logic    cfg_write;

  assign busy      = rst;
  assign cfg_ready = !rst;
  assign accept    = start && !busy;
  assign cfg_write = cfg_valid && cfg_ready;

  // Layout registers
  always_ff @(posedge clk) begin
    if (rst) begin
      layout.pixel_format <= RST_PIXEL_FORMAT;
      layout.line_stride  <= RST_LINE_STRIDE;
      layout.frame_height <= RST_FRAME_HEIGHT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PIXEL_FORMAT: layout.pixel_format <= cfg_data[FMT_W-1:0];
        REG_LINE_STRIDE:  layout.line_stride  <= cfg_data[STRIDE_W-1:0];
        REG_FRAME_HEIGHT: layout.frame_height <= cfg_data[HEIGHT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ysag_addr_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .pixel     (pixel),
    .layout    (layout),
    .out_valid (result_valid),
    .result    (result)
  );

  // Every accepted word comes out as a result, after passing the pipeline valid registers
  a_accept_to_result: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##5 result_valid)
    else $error("accepted pixel produced no result");

  a_result_has_source: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(accept, 5))
    else $error("result without an accepted pixel");

  // index*10 is even, so the bit offset is always even
  a_bit_pos_even: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.bit_pos[0] == 1'b0))
    else $error("odd bit offset");

  a_format_write: assert property (@(posedge clk) disable iff (rst)
    (cfg_write && (cfg_index == REG_PIXEL_FORMAT)) |=>
      (layout.pixel_format == $past(cfg_data[FMT_W-1:0])))
    else $error("pixel format write lost");

endmodule
